// ----- rtl/core/htsp_pkg.sv -----
// htsp_pkg: types and constants for the http status line parser
// transfer payload structs, event and error codes, character constants
// no dependencies
package htsp_pkg;

   // event kinds
   localparam logic [1:0] FUNC_START   = 2'd0;
   localparam logic [1:0] FUNC_BYTE    = 2'd1;
   localparam logic [1:0] FUNC_CLOSED  = 2'd2;
   localparam logic [1:0] FUNC_TIMEOUT = 2'd3;

   // error codes
   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_RESPONSE = 2'd1;
   localparam logic [1:0] ERR_TIMEOUT  = 2'd2;

   // shortest line that can ever succeed, cr lf included
   localparam int unsigned LENGTH_FLOOR = 14;
   localparam int unsigned MIN_LEN_W    = 6;

   localparam logic [7:0] CHAR_CR    = 8'h0d;
   localparam logic [7:0] CHAR_LF    = 8'h0a;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_ONE   = 8'h31;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   typedef struct packed {
      logic [1:0] func;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic       success;
      logic [9:0] status_code;
      logic [1:0] error_code;
   } rsp_type;

   // expected character of the "HTTP/1." prefix at positions 0 to 6
   function automatic logic [7:0] prefix_char(input logic [2:0] pos);
      logic [7:0] c;
      case (pos)
         3'd0:    c = 8'h48; // H
         3'd1:    c = 8'h54; // T
         3'd2:    c = 8'h54; // T
         3'd3:    c = 8'h50; // P
         3'd4:    c = 8'h2f; // /
         3'd5:    c = 8'h31; // 1
         3'd6:    c = 8'h2e; // .
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

// ----- rtl/core/http_status_line_parser.sv -----
// http_status_line_parser: top level, checks an http status line byte by byte
// and reports success with the status code, or an error
// depends on htsp_pkg
//
// path: a result passes the input register, which takes the item at its
// transfer, and then the result register, which takes the result once the
// result register is free or the result side is not stalled
// throughput: one item per cycle while the result side is not stalled
// reset: synchronous; idle, counters cleared, min_line_length back to 14
module http_status_line_parser #(
   parameter int unsigned LINE_CAPACITY = 64
) (
   input  logic               clock,
   input  logic               reset,
   // input channel
   input  logic               req_valid,
   output logic               req_stall,
   input  htsp_pkg::req_type  req_data,
   // result channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output htsp_pkg::rsp_type  rsp_data,
   // configuration port
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [2:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   import htsp_pkg::*;

   // count holds 0 .. LINE_CAPACITY-1
   localparam int unsigned CNT_W = $clog2(LINE_CAPACITY);
   // wide enough for both the count and the minimum length
   localparam int unsigned CMP_W = (CNT_W > MIN_LEN_W) ? CNT_W + 1 : MIN_LEN_W + 1;
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(LINE_CAPACITY - 1);
   localparam logic [2:0] ADDR_MIN_LINE_LENGTH = 3'd0;

   // ---------------------------------------------------------------
   // configuration register
   // ---------------------------------------------------------------
   logic [MIN_LEN_W-1:0] min_len_ff;
   logic                 csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_len_ff <= MIN_LEN_W'(LENGTH_FLOOR);
      end else if (csr_write && csr_paddr[2] == ADDR_MIN_LINE_LENGTH[2]) begin
         min_len_ff <= csr_pwdata[MIN_LEN_W-1:0];
      end
   end

   // only one register, decoded on address bit 2 alone; addresses with bit 2 set read as zero
   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == ADDR_MIN_LINE_LENGTH[2]) begin
         csr_prdata = {{(32-MIN_LEN_W){1'b0}}, min_len_ff};
      end
   end

   // ---------------------------------------------------------------
   // input register: lets one more transfer in while a result waits
   // ---------------------------------------------------------------
   logic    in_valid_ff;
   req_type in_item_ff;
   logic    advance;     // result register free or being emptied
   logic    process;     // item in the input register is worked on

   logic    rsp_valid_ff;
   rsp_type rsp_item_ff;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign process   = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && !req_stall) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_item_ff <= req_data;
      end
   end

   // ---------------------------------------------------------------
   // parser state
   // ---------------------------------------------------------------
   logic             active_ff,      active_in;
   logic [CNT_W-1:0] byte_count_ff,  byte_count_in;
   logic             last_was_cr_ff, last_was_cr_in;
   logic             format_good_ff, format_good_in;
   logic [9:0]       code_accum_ff,  code_accum_in;

   logic             has_result;
   rsp_type          result;

   // per-byte checks
   logic [7:0]       b;
   logic [CNT_W-1:0] pos;
   logic [CNT_W-1:0] count_next;
   logic             is_digit;
   logic             pos_ok;
   logic             good_next;
   logic [9:0]       accum_next;
   logic [9:0]       digit;
   logic             line_end;
   logic             long_enough;

   assign b          = in_item_ff.data_byte;
   assign pos        = byte_count_ff;
   assign count_next = byte_count_ff + CNT_W'(1);
   assign is_digit   = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
   assign digit      = {2'b00, b - CHAR_ZERO};

   // position check over the fixed "HTTP/1.x ddd" head
   always_comb begin
      pos_ok     = 1'b1;
      accum_next = code_accum_ff;
      if (pos < CNT_W'(7)) begin
         pos_ok = (b == prefix_char(pos[2:0]));
      end else if (pos == CNT_W'(7)) begin
         pos_ok = (b == CHAR_ZERO) || (b == CHAR_ONE);
      end else if (pos == CNT_W'(8)) begin
         pos_ok = (b == CHAR_SPACE);
      end else if (pos <= CNT_W'(11)) begin
         pos_ok = is_digit;
         if (is_digit) begin
            // times ten as two shifts and an add, wraps to 10 bits
            accum_next = (code_accum_ff << 3) + (code_accum_ff << 1) + digit;
         end
      end
   end

   assign good_next   = format_good_ff && pos_ok;
   assign line_end    = (count_next >= CNT_W'(2)) && last_was_cr_ff && (b == CHAR_LF);
   assign long_enough = (CMP_W'(count_next) >= CMP_W'(LENGTH_FLOOR))
                     && (CMP_W'(count_next) >= CMP_W'(min_len_ff));

   always_comb begin
      active_in      = active_ff;
      byte_count_in  = byte_count_ff;
      last_was_cr_in = last_was_cr_ff;
      format_good_in = format_good_ff;
      code_accum_in  = code_accum_ff;
      has_result     = 1'b0;
      result         = '{success: 1'b0, status_code: 10'd0, error_code: ERR_RESPONSE};

      if (in_item_ff.func == FUNC_START) begin
         // a line in progress is dropped without a result
         active_in = 1'b1;
      end else if (active_ff) begin
         case (in_item_ff.func)
            FUNC_CLOSED: begin
               has_result = 1'b1;
            end
            FUNC_TIMEOUT: begin
               has_result        = 1'b1;
               result.error_code = ERR_TIMEOUT;
            end
            default: begin
               if (byte_count_ff >= CNT_LAST) begin
                  // overlong line, byte not counted
                  has_result = 1'b1;
               end else if (line_end) begin
                  has_result = 1'b1;
                  if (good_next && long_enough) begin
                     result.success     = 1'b1;
                     result.status_code = accum_next;
                     result.error_code  = ERR_NONE;
                  end
               end else begin
                  byte_count_in  = count_next;
                  last_was_cr_in = (b == CHAR_CR);
                  format_good_in = good_next;
                  code_accum_in  = accum_next;
               end
            end
         endcase
      end

      // start or any ending begins a fresh line
      if (in_item_ff.func == FUNC_START || has_result) begin
         byte_count_in  = '0;
         last_was_cr_in = 1'b0;
         format_good_in = 1'b1;
         code_accum_in  = '0;
      end
      if (has_result) begin
         active_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff      <= 1'b0;
         byte_count_ff  <= '0;
         last_was_cr_ff <= 1'b0;
         format_good_ff <= 1'b1;
         code_accum_ff  <= '0;
      end else if (process) begin
         active_ff      <= active_in;
         byte_count_ff  <= byte_count_in;
         last_was_cr_ff <= last_was_cr_in;
         format_good_ff <= format_good_in;
         code_accum_ff  <= code_accum_in;
      end
   end

   // ---------------------------------------------------------------
   // result register
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= process && has_result;
      end
   end

   always_ff @(posedge clock) begin
      if (process && has_result) begin
         rsp_item_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_item_ff;

   // ---------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------
`ifndef ASSERT_OFF
   // a failed line never carries a status code
   a_fail_no_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_item_ff.success |-> rsp_item_ff.status_code == 10'd0)
      else $error("failure result with non-zero status code");

   // every ending returns the parser to idle with a fresh line
   a_result_idle: assert property (@(posedge clock) disable iff (reset)
      process && has_result |=> !active_ff && byte_count_ff == '0 && format_good_ff)
      else $error("parser not idle after a result");

   // the count never passes the last slot of the line buffer
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      byte_count_ff <= CNT_LAST)
      else $error("byte count beyond line capacity");

   // input is held back only by a waiting, stalled result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid_ff && rsp_stall && in_valid_ff)
      else $error("input stalled without a held result");
`endif

endmodule
